### rtl/bez_pkg.sv
// ---------------------------------------------------------------------------
// bez_pkg
// Shared types and constants of the de Casteljau Bezier evaluator.
// ---------------------------------------------------------------------------
package bez_pkg;

  // Number of control vertex registers
  localparam int NUM_COEF   = 6;
  // Quotient bits kept by each divider (values above 2^33 saturate)
  localparam int QW         = 34;
  // Remainder datapath width: holds divisor << QW
  localparam int DW         = 67;
  // Quotient bits resolved per divider stage
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STEPS  = QW / BITS_PER_STAGE;
  // Blend unit latency: diff, multiply, numerator, divider stages, result
  localparam int BLEND_LAT  = DIV_STEPS + 4;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_ORDER  = 3'd0;
  localparam logic [2:0] REG_COEF_0 = 3'd1;
  localparam logic [2:0] REG_COEF_1 = 3'd2;
  localparam logic [2:0] REG_COEF_2 = 3'd3;
  localparam logic [2:0] REG_COEF_3 = 3'd4;
  localparam logic [2:0] REG_COEF_4 = 3'd5;
  localparam logic [2:0] REG_COEF_5 = 3'd6;

  typedef struct packed {
    logic signed [31:0] param;
    logic signed [31:0] start_req;
    logic signed [31:0] finish;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
  } out_t;

  // Per-item magnitudes shared by every blend of a level
  typedef struct packed {
    logic [32:0] mu;   // |param - start_req|
    logic [32:0] md;   // |finish - start_req|
    logic        sgn;  // sign of (param - start_req) / (finish - start_req)
  } ctl_t;

  // Side band that travels next to the lane data
  typedef struct packed {
    ctl_t       ctl;
    logic [2:0] n;      // clamped order
    logic       empty;  // empty interval
  } side_t;

endpackage

### rtl/bez_blend.sv
// ---------------------------------------------------------------------------
// bez_blend
// Pipelined blend a + u*(b-a)/d, rounded half away from zero, saturated.
// ---------------------------------------------------------------------------
module bez_blend (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  a_in,
  input  logic signed [31:0]  b_in,
  input  bez_pkg::ctl_t       ctl,
  output logic signed [31:0]  c_out
);
  import bez_pkg::*;

  localparam logic [QW-1:0] QLIM = QW'(1) << (QW - 1);

  // Stage A: difference and its magnitude
  logic signed [32:0] diff;
  logic [32:0]        mdiff;
  logic signed [31:0] a_ar;
  logic               en_ar, neg_ar;
  logic [32:0]        mu_ar, md_ar, mdiff_ar;

  assign diff  = {b_in[31], b_in} - {a_in[31], a_in};
  assign mdiff = diff[32] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk) begin
    a_ar     <= a_in;
    en_ar    <= en;
    neg_ar   <= ctl.sgn ^ diff[32];
    mu_ar    <= ctl.mu;
    md_ar    <= ctl.md;
    mdiff_ar <= mdiff;
  end

  // Stage B: product of magnitudes
  logic [65:0]        prod_br;
  logic signed [31:0] a_br;
  logic               en_br, neg_br;
  logic [32:0]        md_br;

  always_ff @(posedge clk) begin
    prod_br <= 66'(mu_ar) * 66'(mdiff_ar);
    a_br    <= a_ar;
    en_br   <= en_ar;
    neg_br  <= neg_ar;
    md_br   <= md_ar;
  end

  // Stage C: add half divisor, flag quotients beyond the kept range
  logic [DW-1:0]      num;
  logic [DW-1:0]      rem_r [DIV_STEPS+1];
  logic [QW-1:0]      q_r   [DIV_STEPS+1];
  logic signed [31:0] a_r   [DIV_STEPS+1];
  logic               en_r  [DIV_STEPS+1];
  logic               neg_r [DIV_STEPS+1];
  logic               ov_r  [DIV_STEPS+1];
  logic [32:0]        md_r  [DIV_STEPS+1];

  assign num = DW'(prod_br) + DW'(md_br >> 1);

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    q_r[0]   <= '0;
    ov_r[0]  <= num >= (DW'(md_br) << QW);
    a_r[0]   <= a_br;
    en_r[0]  <= en_br;
    neg_r[0] <= neg_br;
    md_r[0]  <= md_br;
  end

  // Divider stages: resolve two quotient bits each
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      logic [DW-1:0] sh;
      rem_nxt = rem_r[s];
      q_nxt   = q_r[s];
      for (int t = 0; t < BITS_PER_STAGE; t++) begin
        sh = DW'(md_r[s]) << (QW - 1 - s * BITS_PER_STAGE - t);
        if (rem_nxt >= sh) begin
          rem_nxt = rem_nxt - sh;
          q_nxt[QW - 1 - s * BITS_PER_STAGE - t] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_nxt;
      q_r[s+1]   <= q_nxt;
      ov_r[s+1]  <= ov_r[s];
      a_r[s+1]   <= a_r[s];
      en_r[s+1]  <= en_r[s];
      neg_r[s+1] <= neg_r[s];
      md_r[s+1]  <= md_r[s];
    end
  end

  // Final stage: apply sign, saturate, bypass when the level is idle
  logic               qbig;
  logic signed [35:0] sum;
  logic signed [31:0] res;
  logic signed [31:0] c_r;

  assign qbig = ov_r[DIV_STEPS] || (q_r[DIV_STEPS] > QLIM);
  assign sum  = neg_r[DIV_STEPS]
              ? 36'(a_r[DIV_STEPS]) - $signed({2'b00, q_r[DIV_STEPS]})
              : 36'(a_r[DIV_STEPS]) + $signed({2'b00, q_r[DIV_STEPS]});

  always_comb begin
    if (!en_r[DIV_STEPS]) begin
      res = a_r[DIV_STEPS];
    end else if (qbig) begin
      res = neg_r[DIV_STEPS] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (sum > 36'sd2147483647) begin
      res = 32'sh7fff_ffff;
    end else if (sum < -36'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    c_r <= res;
  end

  assign c_out = c_r;

endmodule

### rtl/bezier_1d_evaluator.sv
// ---------------------------------------------------------------------------
// bezier_1d_evaluator
// One-dimensional Bezier evaluation by de Casteljau over a mapped interval.
// ---------------------------------------------------------------------------
// Takes one item per clock (busy is always low) and returns exactly one
// result per item, in order, registered through a chain of de Casteljau
// levels, each a 21-stage blend unit whose divider resolves two quotient
// bits per stage. Results appear on out_data for one cycle with
// out_valid; the receiver must take them. Lower orders pass through the
// same levels, with the unused levels passing data through.
// Configuration writes are only legal while no item is in flight.
module bezier_1d_evaluator #(
  parameter int MAX_ORDER = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bez_pkg::in_t   in_data,
  output logic           out_valid,
  output bez_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import bez_pkg::*;

  localparam int LIM    = (MAX_ORDER < NUM_COEF) ? MAX_ORDER : NUM_COEF;
  localparam int LEVELS = LIM - 1;
  localparam int PLAT   = LEVELS * BLEND_LAT;
  localparam int VW     = PLAT + 1;

  // Configuration registers
  logic [2:0]         order_r;
  logic signed [31:0] coef_r [NUM_COEF];
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd1;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORDER:  order_r   <= pwdata[2:0];
        REG_COEF_0: coef_r[0] <= pwdata;
        REG_COEF_1: coef_r[1] <= pwdata;
        REG_COEF_2: coef_r[2] <= pwdata;
        REG_COEF_3: coef_r[3] <= pwdata;
        REG_COEF_4: coef_r[4] <= pwdata;
        REG_COEF_5: coef_r[5] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ORDER:  prdata = {29'd0, order_r};
      REG_COEF_0: prdata = coef_r[0];
      REG_COEF_1: prdata = coef_r[1];
      REG_COEF_2: prdata = coef_r[2];
      REG_COEF_3: prdata = coef_r[3];
      REG_COEF_4: prdata = coef_r[4];
      REG_COEF_5: prdata = coef_r[5];
      default:    prdata = '0;
    endcase
  end

  // Entry stage: interval offsets, magnitudes, clamped order
  logic signed [32:0] u_s, d_s;
  logic [2:0]         n_clamp;
  side_t              side_nxt;

  assign u_s = {in_data.param[31], in_data.param} - {in_data.start_req[31], in_data.start_req};
  assign d_s = {in_data.finish[31], in_data.finish} - {in_data.start_req[31], in_data.start_req};

  always_comb begin
    if (order_r == 3'd0) begin
      n_clamp = 3'd1;
    end else if (order_r > 3'(LIM)) begin
      n_clamp = 3'(LIM);
    end else begin
      n_clamp = order_r;
    end
  end

  always_comb begin
    side_nxt.ctl.mu  = u_s[32] ? 33'(-u_s) : 33'(u_s);
    side_nxt.ctl.md  = d_s[32] ? 33'(-d_s) : 33'(d_s);
    side_nxt.ctl.sgn = u_s[32] ^ d_s[32];
    side_nxt.n       = n_clamp;
    side_nxt.empty   = (d_s == '0);
  end

  // Valid bits and side band, in step with the blend units
  logic [PLAT:0]      vld_r;
  side_t              side_r [PLAT+1];
  logic signed [31:0] cdat [LEVELS+1][NUM_COEF];
  logic signed [31:0] c0_r [NUM_COEF];

  // Advance the valid bits one stage per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= VW'({vld_r, start});
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int i = 0; i < NUM_COEF; i++) begin
      c0_r[i] <= coef_r[i];
    end
  end

  for (genvar i = 0; i < PLAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      side_r[i+1] <= side_r[i];
    end
  end

  for (genvar j = 0; j < NUM_COEF; j++) begin : g_c0
    assign cdat[0][j] = c0_r[j];
  end

  // De Casteljau levels: each blends neighboring vertices
  for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
    logic lvl_en;
    assign lvl_en = (side_r[(k-1)*BLEND_LAT].n > 3'(k)) && !side_r[(k-1)*BLEND_LAT].empty;

    for (genvar j = 0; j < NUM_COEF; j++) begin : g_lane
      if (j < NUM_COEF - k) begin : g_act
        bez_blend u_blend (
          .clk   (clk),
          .en    (lvl_en),
          .a_in  (cdat[k-1][j]),
          .b_in  (cdat[k-1][j+1]),
          .ctl   (side_r[(k-1)*BLEND_LAT].ctl),
          .c_out (cdat[k][j])
        );
      end else begin : g_idle
        assign cdat[k][j] = '0;
      end
    end
  end

  // Output register
  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[PLAT];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.value  <= cdat[LEVELS][0];
    out_data_r.status <= side_r[PLAT].empty;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Results appear a fixed time after the transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PLAT + 2))
    else $error("result without matching transfer");

  // Empty interval returns the first vertex
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.value == coef_r[0]))
    else $error("empty interval value mismatch");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule
